// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent check forms for the triangulator.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication, masked during reset
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication, active during reset too
`define CHK_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error("check failed");

`endif

// ===== src/mcct_pkg.sv =====
// ---------------------------------------------------------------------------
// mcct_pkg
// Types, codes and lookup tables of the marching cubes cell triangulator.
// ---------------------------------------------------------------------------
package mcct_pkg;

    localparam int CFG_DW    = 32;
    localparam int CFG_IW    = 2;
    localparam int ISO_W     = 32;
    localparam int CS_W      = 31;
    localparam int CNT_W     = 32;
    localparam int ROW_W     = 60;
    localparam int DIV_CW    = $clog2(CS_W);

    localparam logic [CFG_IW-1:0] CFG_ISO_LEVEL = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_CELL_SIZE = 2'd1;

    localparam logic [3:0] EDGE_NONE = 4'hf;
    localparam logic [3:0] EDGE_LAST = 4'hb;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EDGE,
        BK_MUL,
        BK_DIV,
        BK_PLACE,
        BK_EMIT
    } t_bk_state;

    // edge digits per case, one per nibble of the row, first digit in the top nibble, unused as f
    localparam logic [ROW_W-1:0] TRI_ROWS [256] = '{
        60'hfffffffffffffff, 60'h083ffffffffffff, 60'h019ffffffffffff, 60'h183981fffffffff,
        60'h12affffffffffff, 60'h08312afffffffff, 60'h92a029fffffffff, 60'h2832a8a98ffffff,
        60'h3b2ffffffffffff, 60'h0b28b0fffffffff, 60'h19023bfffffffff, 60'h1b219b98bffffff,
        60'h3a1ba3fffffffff, 60'h0a108a8baffffff, 60'h3903b9ba9ffffff, 60'h98aa8bfffffffff,
        60'h478ffffffffffff, 60'h430734fffffffff, 60'h019847fffffffff, 60'h419471731ffffff,
        60'h12a847fffffffff, 60'h34730412affffff, 60'h92a902847ffffff, 60'h2a9297273794fff,
        60'h8473b2fffffffff, 60'hb47b24204ffffff, 60'h90184723bffffff, 60'h47b94b9b2921fff,
        60'h3a13ba784ffffff, 60'h1ba14b1047b4fff, 60'h47890b9bab03fff, 60'h47b4b99baffffff,
        60'h954ffffffffffff, 60'h954083fffffffff, 60'h054150fffffffff, 60'h854835315ffffff,
        60'h12a954fffffffff, 60'h30812a495ffffff, 60'h52a542402ffffff, 60'h2a5325354348fff,
        60'h95423bfffffffff, 60'h0b208b495ffffff, 60'h05401523bffffff, 60'h21525828b485fff,
        60'ha3ba13954ffffff, 60'h4950818a18bafff, 60'h54050b5bab03fff, 60'h54858aa8bffffff,
        60'h978579fffffffff, 60'h930953573ffffff, 60'h078017157ffffff, 60'h153357fffffffff,
        60'h978957a12ffffff, 60'ha12950530573fff, 60'h802825857a52fff, 60'h2a5253357ffffff,
        60'h7957893b2ffffff, 60'h95797292027bfff, 60'h23b018178157fff, 60'hb21b17715ffffff,
        60'h958857a13a3bfff, 60'h5705097b010aba0, 60'hba0b03a50807570, 60'hba57b5fffffffff,
        60'ha65ffffffffffff, 60'h0835a6fffffffff, 60'h9015a6fffffffff, 60'h1831985a6ffffff,
        60'h165261fffffffff, 60'h165126308ffffff, 60'h965906026ffffff, 60'h598582526328fff,
        60'h23ba65fffffffff, 60'hb08b20a65ffffff, 60'h01923b5a6ffffff, 60'h5a61929b298bfff,
        60'h63b653513ffffff, 60'h08b0b50515b6fff, 60'h3b6036065059fff, 60'h65969bb98ffffff,
        60'h5a6478fffffffff, 60'h43047365affffff, 60'h1905a6847ffffff, 60'ha65197173794fff,
        60'h612651478ffffff, 60'h125526304347fff, 60'h847905065026fff, 60'h739794329596269,
        60'h3b2784a65ffffff, 60'h5a647242027bfff, 60'h01947823b5a6fff, 60'h9219b294b7b45a6,
        60'h8473b53515b6fff, 60'h51b5b610b7b404b, 60'h059065036b63847, 60'h65969b4797b9fff,
        60'ha4964afffffffff, 60'h4a649a083ffffff, 60'ha01a60640ffffff, 60'h83181686461afff,
        60'h149124264ffffff, 60'h308129249264fff, 60'h024426fffffffff, 60'h832824426ffffff,
        60'ha49a64b23ffffff, 60'h08228b49a4a6fff, 60'h3b201606461afff, 60'h64161a48121b8b1,
        60'h964936913b63fff, 60'h8b1810b61914641, 60'h3b6360064ffffff, 60'h648b68fffffffff,
        60'h7a678a89affffff, 60'h0730a709a67afff, 60'ha671a7178180fff, 60'ha67a71173ffffff,
        60'h126168189867fff, 60'h269291679093739, 60'h780706602ffffff, 60'h732672fffffffff,
        60'h23ba68a89867fff, 60'h20727b09767a9a7, 60'h1801781a767a23b, 60'hb21b17a61671fff,
        60'h896867916b63136, 60'h091b67fffffffff, 60'h7807063b0b60fff, 60'h7b6ffffffffffff,
        60'h76bffffffffffff, 60'h30876bfffffffff, 60'h01976bfffffffff, 60'h819831b76ffffff,
        60'ha126b7fffffffff, 60'h12a3086b7ffffff, 60'h2902a96b7ffffff, 60'h6b72a3a83a98fff,
        60'h723627fffffffff, 60'h708760620ffffff, 60'h276237019ffffff, 60'h162186198876fff,
        60'ha76a17137ffffff, 60'ha7617a187108fff, 60'h03707a0a96a7fff, 60'h76a7a88a9ffffff,
        60'h684b86fffffffff, 60'h36b306046ffffff, 60'h86b846901ffffff, 60'h946963931b36fff,
        60'h6846b82a1ffffff, 60'h12a30b06b046fff, 60'h4b846b0292a9fff, 60'ha93a32943b36463,
        60'h823842462ffffff, 60'h042462fffffffff, 60'h190234246438fff, 60'h194142246ffffff,
        60'h8138618466a1fff, 60'ha10a06604ffffff, 60'h4634386a3039a93, 60'ha946a4fffffffff,
        60'h49576bfffffffff, 60'h083495b76ffffff, 60'h50154076bffffff, 60'hb76834354315fff,
        60'h954a1276bffffff, 60'h6b712a083495fff, 60'h76b54a42a402fff, 60'h348354325a52b76,
        60'h723762549ffffff, 60'h954086062687fff, 60'h362376150540fff, 60'h628687218485158,
        60'h954a16176137fff, 60'h16a176107870954, 60'h40a4a503a6a737a, 60'h76a7a854a48afff,
        60'h6956b9b89ffffff, 60'h36b063056095fff, 60'h0b805b01556bfff, 60'h6b3635531ffffff,
        60'h12a95b9b8b56fff, 60'h0b306b09656912a, 60'hb85b56805a52025, 60'h6b36352a3a53fff,
        60'h589528562382fff, 60'h956960062ffffff, 60'h158180568382628, 60'h156216fffffffff,
        60'h13616a386569896, 60'ha10a06950560fff, 60'h03856afffffffff, 60'ha56ffffffffffff,
        60'hb5a75bfffffffff, 60'hb5ab75830ffffff, 60'h5b75ab190ffffff, 60'ha75ab7981831fff,
        60'hb12b71751ffffff, 60'h08312717572bfff, 60'h9759279022b7fff, 60'h75272b592328982,
        60'h25a235375ffffff, 60'h820852875a25fff, 60'h9015a35373a2fff, 60'h982921872a25752,
        60'h135375fffffffff, 60'h087071175ffffff, 60'h903935537ffffff, 60'h987597fffffffff,
        60'h5845a8ab8ffffff, 60'h5045b05abb30fff, 60'h01984a8aba45fff, 60'hab4a45b34941314,
        60'h2512852b8458fff, 60'h04b0b345b2b151b, 60'h0250592b5458b85, 60'h9452b3fffffffff,
        60'h25a352345384fff, 60'h5a2524420ffffff, 60'h3a235a385458019, 60'h5a2524192942fff,
        60'h845853351ffffff, 60'h045105fffffffff, 60'h845853905035fff, 60'h945ffffffffffff,
        60'h4b749b9abffffff, 60'h0834979b79abfff, 60'h1ab1b414074bfff, 60'h3143481a474bab4,
        60'h4b79b492b912fff, 60'h9749b791b2b1083, 60'hb74b42240ffffff, 60'hb74b42834324fff,
        60'h29a279237749fff, 60'h9a7974a27870207, 60'h37a3a274a1a040a, 60'h1a2874fffffffff,
        60'h491417713ffffff, 60'h491417081871fff, 60'h403743fffffffff, 60'h487ffffffffffff,
        60'h9a8ab8fffffffff, 60'h30939bb9affffff, 60'h01a0a88abffffff, 60'h31ab3afffffffff,
        60'h12b1b99b8ffffff, 60'h30939b1292b9fff, 60'h02b80bfffffffff, 60'h32bffffffffffff,
        60'h23828aa89ffffff, 60'h9a2092fffffffff, 60'h23828a0181a8fff, 60'h1a2ffffffffffff,
        60'h138918fffffffff, 60'h091ffffffffffff, 60'h038ffffffffffff, 60'hfffffffffffffff
    };

    function automatic logic [2:0] row_tris(input logic [ROW_W-1:0] row);
        logic [2:0] n;
        if (row[59:56] == EDGE_NONE) n = 3'd0;
        else if (row[47:44] == EDGE_NONE) n = 3'd1;
        else if (row[35:32] == EDGE_NONE) n = 3'd2;
        else if (row[23:20] == EDGE_NONE) n = 3'd3;
        else if (row[11:8] == EDGE_NONE) n = 3'd4;
        else n = 3'd5;
        return n;
    endfunction

    // corner offset along axis k (0 x, 1 y, 2 z)
    function automatic logic corner_pos(input logic [2:0] c, input logic [1:0] k);
        logic p;
        unique case (k)
            2'd0:    p = (c == 3'd1) || (c == 3'd2) || (c == 3'd5) || (c == 3'd6);
            2'd1:    p = (c == 3'd2) || (c == 3'd3) || (c == 3'd6) || (c == 3'd7);
            default: p = c[2];
        endcase
        return p;
    endfunction

endpackage

// ===== src/mcct_front.sv =====
// ---------------------------------------------------------------------------
// mcct_front
// Accepts cells, forms the case index, looks up the triangle row and queues
// non-empty cells for the back end.
// ---------------------------------------------------------------------------
module mcct_front #(
    parameter int VW = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [VW-1:0]               i_org [3],
    input  logic [VW-1:0]               i_val [8],
    input  logic signed [mcct_pkg::ISO_W-1:0] i_iso,
    output mcct_pkg::t_q_status         o_q_status,
    input  logic                        i_q_pop,
    output logic [11*VW+mcct_pkg::ROW_W-1:0] o_q_data
);
    import mcct_pkg::*;

    localparam int EW = ((VW > ISO_W) ? VW : ISO_W) + 1;
    localparam int QW = 11 * VW + ROW_W;

    logic [QW-1:0]       r_q [2];
    logic                r_wp;
    logic                r_rp;
    logic [1:0]          r_cnt;
    logic [7:0]          case_idx;
    logic [ROW_W-1:0]    row;
    logic                accept;
    logic                push;
    logic signed [EW-1:0] iso_e;

    assign iso_e = EW'(i_iso);

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            case_idx[i] = $signed({i_val[i][VW-1], i_val[i]}) < iso_e;
        end
    end

    assign row    = TRI_ROWS[case_idx];
    assign accept = i_in_valid && !o_in_stall;
    assign push   = accept && (row_tris(row) != 3'd0);

    assign o_in_stall          = (r_cnt == 2'd2);
    assign o_q_status.full     = (r_cnt == 2'd2);
    assign o_q_status.not_empty = (r_cnt != 2'd0);
    assign o_q_data            = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (i_q_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= {i_org[0], i_org[1], i_org[2],
                          i_val[0], i_val[1], i_val[2], i_val[3],
                          i_val[4], i_val[5], i_val[6], i_val[7], row};
        end
    end

endmodule

// ===== src/mcct_back.sv =====
// ---------------------------------------------------------------------------
// mcct_back
// Walks the triangle row of one cell, places each vertex with a shared
// multiplier and a bit-serial divider, and emits one triangle per item.
// ---------------------------------------------------------------------------
module mcct_back #(
    parameter int VW = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mcct_pkg::t_q_status         i_q_status,
    output logic                        o_q_pop,
    input  logic [11*VW+mcct_pkg::ROW_W-1:0] i_q_data,
    input  logic signed [mcct_pkg::ISO_W-1:0] i_iso,
    input  logic [mcct_pkg::CS_W-1:0]   i_cs,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [VW-1:0]               o_vert [9],
    output logic [mcct_pkg::CNT_W-1:0]  o_base,
    output logic                        o_last
);
    import mcct_pkg::*;

    localparam int EW = ((VW > ISO_W) ? VW : ISO_W) + 1;
    localparam int PW = CS_W + EW;
    localparam int CW = ((VW > CS_W) ? VW : CS_W) + 3;
    localparam logic signed [CW-1:0] SAT_HI = {{(CW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [CW-1:0] SAT_LO = ~SAT_HI;

    t_bk_state          r_state, n_state;
    logic [VW-1:0]      r_org [3];
    logic [VW-1:0]      r_val [8];
    logic [ROW_W-1:0]   r_row;
    logic [2:0]         r_ntri;
    logic [2:0]         r_tri;
    logic [1:0]         r_vtx;
    logic [2:0]         r_a, r_b;
    logic               r_at_b;
    logic [EW-1:0]      r_mn, r_md;
    logic [EW-1:0]      r_rem;
    logic [CS_W-1:0]    r_low;
    logic [DIV_CW-1:0]  r_dcnt;
    logic [VW-1:0]      r_vp [3][3];
    logic [CNT_W-1:0]   r_vcnt;
    logic               r_ov;

    logic [3:0]         dig_idx;
    logic [3:0]         e;
    logic [ROW_W-1:0]   row_sh;
    logic [2:0]         ea, eb;
    logic [VW-1:0]      va, vb;
    logic signed [EW-1:0] iso_e, va_e, vb_e, num, den;
    logic [EW-1:0]      mn, md;
    logic               do_div, at_b;
    logic [PW-1:0]      prod;
    logic [EW:0]        dtrial;
    logic [EW:0]        dsub;
    logic               emit;
    logic               out_acc;
    logic signed [CW-1:0] coord [3];

    assign dig_idx = 4'(r_tri) * 4'd3 + 4'(r_vtx);
    assign row_sh  = r_row << {dig_idx, 2'b00};
    assign e       = (row_sh[59:56] > EDGE_LAST) ? EDGE_LAST : row_sh[59:56];

    always_comb begin
        unique case (e)
            4'd0:    begin ea = 3'd0; eb = 3'd1; va = r_val[0]; vb = r_val[1]; end
            4'd1:    begin ea = 3'd1; eb = 3'd2; va = r_val[1]; vb = r_val[2]; end
            4'd2:    begin ea = 3'd2; eb = 3'd3; va = r_val[2]; vb = r_val[3]; end
            4'd3:    begin ea = 3'd3; eb = 3'd0; va = r_val[3]; vb = r_val[0]; end
            4'd4:    begin ea = 3'd4; eb = 3'd5; va = r_val[4]; vb = r_val[5]; end
            4'd5:    begin ea = 3'd5; eb = 3'd6; va = r_val[5]; vb = r_val[6]; end
            4'd6:    begin ea = 3'd6; eb = 3'd7; va = r_val[6]; vb = r_val[7]; end
            4'd7:    begin ea = 3'd7; eb = 3'd4; va = r_val[7]; vb = r_val[4]; end
            4'd8:    begin ea = 3'd0; eb = 3'd4; va = r_val[0]; vb = r_val[4]; end
            4'd9:    begin ea = 3'd1; eb = 3'd5; va = r_val[1]; vb = r_val[5]; end
            4'd10:   begin ea = 3'd2; eb = 3'd6; va = r_val[2]; vb = r_val[6]; end
            default: begin ea = 3'd3; eb = 3'd7; va = r_val[3]; vb = r_val[7]; end
        endcase
    end

    assign iso_e = EW'(i_iso);
    assign va_e  = $signed({va[VW-1], va});
    assign vb_e  = $signed({vb[VW-1], vb});
    assign num   = iso_e - va_e;
    assign den   = vb_e - va_e;
    assign mn    = num[EW-1] ? EW'(-num) : EW'(num);
    assign md    = den[EW-1] ? EW'(-den) : EW'(den);

    always_comb begin
        do_div = 1'b0;
        at_b   = 1'b0;
        priority if (num == '0) begin
            at_b = 1'b0;
        end else if (iso_e == vb_e) begin
            at_b = 1'b1;
        end else if (den != '0) begin
            priority if (num[EW-1] != den[EW-1]) at_b = 1'b0;
            else if (mn >= md) at_b = 1'b1;
            else do_div = 1'b1;
        end else begin
            at_b = 1'b0;
        end
    end

    assign prod   = PW'(i_cs) * PW'(r_mn) + PW'(r_md >> 1);
    assign dtrial = {r_rem, r_low[CS_W-1]};
    assign dsub   = dtrial - {1'b0, r_md};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [CW-1:0] org_c, ca, cb, p;
            org_c = CW'($signed(r_org[k]));
            ca = org_c + (corner_pos(r_a, 2'(k)) ? CW'(i_cs) : '0);
            cb = org_c + (corner_pos(r_b, 2'(k)) ? CW'(i_cs) : '0);
            priority if (r_at_b) p = cb;
            else if (corner_pos(r_b, 2'(k)) && !corner_pos(r_a, 2'(k))) p = ca + CW'(r_low);
            else if (corner_pos(r_a, 2'(k)) && !corner_pos(r_b, 2'(k))) p = ca - CW'(r_low);
            else p = ca;
            priority if (p > SAT_HI) coord[k] = SAT_HI;
            else if (p < SAT_LO) coord[k] = SAT_LO;
            else coord[k] = p;
        end
    end

    assign out_acc = r_ov && !i_out_stall;
    assign emit    = (r_state == BK_EMIT) && (!r_ov || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= BK_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_q_pop = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_status.not_empty) begin
                    o_q_pop = 1'b1;
                    n_state = BK_EDGE;
                end
            end
            BK_EDGE:  n_state = do_div ? BK_MUL : BK_PLACE;
            BK_MUL:   n_state = BK_DIV;
            BK_DIV:   if (r_dcnt == DIV_CW'(CS_W - 1)) n_state = BK_PLACE;
            BK_PLACE: n_state = (r_vtx == 2'd2) ? BK_EMIT : BK_EDGE;
            BK_EMIT: begin
                if (emit) n_state = (r_tri + 3'd1 == r_ntri) ? BK_IDLE : BK_EDGE;
            end
            default:  n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_vcnt <= '0;
        end else begin
            if (emit) begin
                r_ov   <= 1'b1;
                r_vcnt <= r_vcnt + CNT_W'(3);
            end else if (out_acc) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_status.not_empty) begin
                    for (int k = 0; k < 3; k++)
                        r_org[k] <= i_q_data[11*VW+ROW_W-1-k*VW -: VW];
                    for (int i = 0; i < 8; i++)
                        r_val[i] <= i_q_data[8*VW+ROW_W-1-i*VW -: VW];
                    r_row  <= i_q_data[ROW_W-1:0];
                    r_ntri <= row_tris(i_q_data[ROW_W-1:0]);
                    r_tri  <= 3'd0;
                    r_vtx  <= 2'd0;
                end
            end
            BK_EDGE: begin
                r_a    <= ea;
                r_b    <= eb;
                r_at_b <= at_b;
                r_mn   <= mn;
                r_md   <= md;
                if (!do_div) r_low <= '0;
            end
            BK_MUL: begin
                r_rem  <= prod[PW-1:CS_W];
                r_low  <= prod[CS_W-1:0];
                r_dcnt <= '0;
            end
            BK_DIV: begin
                if (!dsub[EW]) begin
                    r_rem <= dsub[EW-1:0];
                    r_low <= {r_low[CS_W-2:0], 1'b1};
                end else begin
                    r_rem <= dtrial[EW-1:0];
                    r_low <= {r_low[CS_W-2:0], 1'b0};
                end
                r_dcnt <= r_dcnt + DIV_CW'(1);
            end
            BK_PLACE: begin
                for (int k = 0; k < 3; k++) r_vp[r_vtx][k] <= coord[k][VW-1:0];
                r_vtx <= r_vtx + 2'd1;
            end
            BK_EMIT: begin
                if (emit) begin
                    for (int v = 0; v < 3; v++)
                        for (int k = 0; k < 3; k++) o_vert[v*3+k] <= r_vp[v][k];
                    o_base <= r_vcnt;
                    o_last <= (r_tri + 3'd1 == r_ntri);
                    r_tri  <= r_tri + 3'd1;
                    r_vtx  <= 2'd0;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ov;

endmodule

// ===== src/marching_cubes_cell_triangulator_unit.sv =====
// ---------------------------------------------------------------------------
// marching_cubes_cell_triangulator_unit
// Triangulates one cube cell per input item into up to five triangles.
// ---------------------------------------------------------------------------
// channel   dir  handshake               payload
// in        in   i_in_valid / o_in_stall  origin xyz, eight corner values
// out       out  o_out_valid / i_out_stall three vertices, base index, last
// cfg       in   i_cfg_valid / o_cfg_ready index, data
//
// An edge needing interpolation passes the edge and multiply states, 31
// divider steps and the place state; an edge at a corner goes from edge
// straight to place; a triangle adds an emit state after its three vertices.
// The front queues two non-empty cells and accepts until both slots are full.
// Reset is synchronous, active low; no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module marching_cubes_cell_triangulator_unit #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_origin_x,
    input  logic signed [VALUE_WIDTH-1:0] i_origin_y,
    input  logic signed [VALUE_WIDTH-1:0] i_origin_z,
    input  logic signed [VALUE_WIDTH-1:0] i_corner_value_0,
    input  logic signed [VALUE_WIDTH-1:0] i_corner_value_1,
    input  logic signed [VALUE_WIDTH-1:0] i_corner_value_2,
    input  logic signed [VALUE_WIDTH-1:0] i_corner_value_3,
    input  logic signed [VALUE_WIDTH-1:0] i_corner_value_4,
    input  logic signed [VALUE_WIDTH-1:0] i_corner_value_5,
    input  logic signed [VALUE_WIDTH-1:0] i_corner_value_6,
    input  logic signed [VALUE_WIDTH-1:0] i_corner_value_7,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [VALUE_WIDTH-1:0] o_vert_a_x,
    output logic signed [VALUE_WIDTH-1:0] o_vert_a_y,
    output logic signed [VALUE_WIDTH-1:0] o_vert_a_z,
    output logic signed [VALUE_WIDTH-1:0] o_vert_b_x,
    output logic signed [VALUE_WIDTH-1:0] o_vert_b_y,
    output logic signed [VALUE_WIDTH-1:0] o_vert_b_z,
    output logic signed [VALUE_WIDTH-1:0] o_vert_c_x,
    output logic signed [VALUE_WIDTH-1:0] o_vert_c_y,
    output logic signed [VALUE_WIDTH-1:0] o_vert_c_z,
    output logic [mcct_pkg::CNT_W-1:0]  o_base_vertex_index,
    output logic                        o_last_triangle,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mcct_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [mcct_pkg::CFG_DW-1:0] i_cfg_data
);
    import mcct_pkg::*;

    localparam logic [CS_W-1:0] CS_RESET =
        (FRAC_BITS < CS_W) ? (CS_W'(1) << FRAC_BITS) : '0;

    logic signed [ISO_W-1:0] r_iso;
    logic [CS_W-1:0]         r_cs;
    logic [VALUE_WIDTH-1:0]  org [3];
    logic [VALUE_WIDTH-1:0]  val [8];
    logic [VALUE_WIDTH-1:0]  vert [9];
    t_q_status               q_status;
    logic                    q_pop;
    logic [11*VALUE_WIDTH+ROW_W-1:0] q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iso <= '0;
            r_cs  <= CS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ISO_LEVEL: r_iso <= $signed(i_cfg_data[ISO_W-1:0]);
                CFG_CELL_SIZE: r_cs  <= i_cfg_data[CS_W-1:0];
                default: ;
            endcase
        end
    end

    assign org = '{i_origin_x, i_origin_y, i_origin_z};
    assign val = '{i_corner_value_0, i_corner_value_1, i_corner_value_2, i_corner_value_3,
                   i_corner_value_4, i_corner_value_5, i_corner_value_6, i_corner_value_7};

    mcct_front #(.VW(VALUE_WIDTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_org      (org),
        .i_val      (val),
        .i_iso      (r_iso),
        .o_q_status (q_status),
        .i_q_pop    (q_pop),
        .o_q_data   (q_data)
    );

    mcct_back #(.VW(VALUE_WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .o_q_pop     (q_pop),
        .i_q_data    (q_data),
        .i_iso       (r_iso),
        .i_cs        (r_cs),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_vert      (vert),
        .o_base      (o_base_vertex_index),
        .o_last      (o_last_triangle)
    );

    assign o_vert_a_x = vert[0];
    assign o_vert_a_y = vert[1];
    assign o_vert_a_z = vert[2];
    assign o_vert_b_x = vert[3];
    assign o_vert_b_y = vert[4];
    assign o_vert_b_z = vert[5];
    assign o_vert_c_x = vert[6];
    assign o_vert_c_y = vert[7];
    assign o_vert_c_z = vert[8];

    `CHK_IMPL(a_pop_not_empty, i_clk, i_rst_n, q_pop, q_status.not_empty)
    `CHK_IMPL(a_full_stalls, i_clk, i_rst_n, q_status.full, o_in_stall && q_status.not_empty)
    `CHK_NEXT(a_rst_out_idle, i_clk, !i_rst_n, !o_out_valid)

endmodule
